### src/tmse_pkg.sv
`default_nettype none
package tmse_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int WORD_WIDTH_DEF  = 32;

	localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
	localparam logic signed [63:0] K_Q30       = 64'sd652032874;
	localparam logic signed [63:0] PI_Q30      = 64'sd3373259426;
	localparam logic signed [63:0] HALF_PI_Q30 = 64'sd1686629713;
	localparam logic signed [63:0] TWO_PI_Q30  = 64'sd6746518852;

	typedef enum logic [3:0] {
		CMD_TRANSLATE = 4'd0,
		CMD_SCALE     = 4'd1,
		CMD_ROTATE    = 4'd2,
		CMD_PERSP     = 4'd3,
		CMD_ORIENT    = 4'd4,
		CMD_SHADOW    = 4'd5,
		CMD_PUSH      = 4'd6,
		CMD_POP       = 4'd7,
		CMD_POPPUSH   = 4'd8,
		CMD_XFORM     = 4'd9
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_POP_EMPTY = 3'd1,
		ST_PUSH_FULL = 3'd2,
		ST_BAD_AXIS  = 3'd3,
		ST_DIV_ZERO  = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_REDUCE, S_MOD, S_CORDIC, S_DIV, S_NEGQ, S_MAC,
		S_WRITE, S_PUSH, S_POP, S_DONE
	} state_t;

	typedef struct packed {
		logic [3:0]         cmd;
		logic signed [31:0] p0;
		logic signed [31:0] p1;
		logic signed [31:0] p2;
		logic signed [31:0] p3;
		logic signed [31:0] p4;
		logic signed [31:0] p5;
		logic signed [31:0] p6;
		logic signed [31:0] p7;
		logic signed [31:0] p8;
		logic [1:0]         axis;
		logic               local_light;
	} cmd_in_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic signed [31:0] out_w;
		logic [2:0]         status;
	} res_out_t;

	// CORDIC arctangent table in Q2.30.
	function automatic logic signed [63:0] atan_q30(input logic [4:0] i);
		logic signed [63:0] r;
		begin
			unique case (i)
				5'd0:  r = 64'sd843314857;
				5'd1:  r = 64'sd497837829;
				5'd2:  r = 64'sd263043837;
				5'd3:  r = 64'sd133525159;
				5'd4:  r = 64'sd67021687;
				5'd5:  r = 64'sd33543516;
				5'd6:  r = 64'sd16775851;
				5'd7:  r = 64'sd8388437;
				5'd8:  r = 64'sd4194283;
				5'd9:  r = 64'sd2097149;
				5'd10: r = 64'sd1048576;
				default: r = 64'sd1 <<< (30 - i);
			endcase
			return r;
		end
	endfunction

endpackage
`default_nettype wire

### src/tmse_cordic.sv
`default_nettype none
module tmse_cordic #(
	parameter int EB = 32
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  wire signed [63:0] ang,
	output logic              done,
	output logic signed [31:0] sin_q16,
	output logic signed [31:0] cos_q16
);
	import tmse_pkg::*;

	localparam logic signed [63:0] HI = (64'sd1 <<< (EB - 1)) - 64'sd1;
	localparam logic signed [63:0] LO = -HI - 64'sd1;

	logic signed [63:0] x_q, y_q, z_q;
	logic [4:0] it_q;
	logic run_q, neg_q, done_q;
	logic signed [63:0] r0, r1, r2;
	logic fneg;
	logic signed [63:0] dx, dy, xr, yr;
	logic signed [31:0] xs, ys;

	// Fold the reduced angle into the range of convergence.
	always_comb begin
		r0 = ang;
		r1 = r0;
		if (r0 > PI_Q30) r1 = r0 - TWO_PI_Q30;
		else if (r0 < -PI_Q30) r1 = r0 + TWO_PI_Q30;
		fneg = 1'b0;
		r2 = r1;
		if (r1 > HALF_PI_Q30) begin
			r2 = PI_Q30 - r1;
			fneg = 1'b1;
		end else if (r1 < -HALF_PI_Q30) begin
			r2 = -PI_Q30 - r1;
			fneg = 1'b1;
		end
		dx = y_q >>> it_q;
		dy = x_q >>> it_q;
		xr = (x_q + 64'sd8192) >>> 14;
		yr = (y_q + 64'sd8192) >>> 14;
		// Saturate to the entry width before the cosine sign is applied.
		if (xr > HI) xs = HI[31:0];
		else if (xr < LO) xs = LO[31:0];
		else xs = xr[31:0];
		if (yr > HI) ys = HI[31:0];
		else if (yr < LO) ys = LO[31:0];
		else ys = yr[31:0];
	end

	// One micro-rotation per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				it_q  <= '0;
			end else if (run_q) begin
				it_q <= it_q + 5'd1;
				if (it_q == 5'd29) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= K_Q30;
			y_q   <= '0;
			z_q   <= r2;
			neg_q <= fneg;
		end else if (run_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_q30(it_q);
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_q30(it_q);
			end
		end
	end

	assign done    = done_q;
	assign sin_q16 = ys;
	assign cos_q16 = neg_q ? -xs : xs;
endmodule
`default_nettype wire

### src/tmse_divider.sv
`default_nettype none
module tmse_divider (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	input  wire [63:0] num,
	input  wire [63:0] den,
	output logic       done,
	output logic [63:0] quo
);
	logic [63:0] q_q;
	logic [64:0] r_q;
	logic [63:0] d_q;
	logic [6:0]  cnt_q;
	logic run_q, done_q;
	logic [64:0] trial;

	always_comb trial = {r_q[63:0], q_q[63]} - {1'b0, d_q};

	// Restoring division, one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (run_q) begin
			if (!trial[64]) begin
				r_q <= trial;
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				r_q <= {r_q[63:0], q_q[63]};
				q_q <= {q_q[62:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = q_q;
endmodule
`default_nettype wire

### src/tmse_mac.sv
`default_nettype none
module tmse_mac #(
	parameter int EB = 32
) (
	input  wire               clk,
	input  wire               clr,
	input  wire               en,
	input  wire signed [31:0] a,
	input  wire signed [31:0] b,
	output logic signed [31:0] res
);
	logic signed [63:0] prod_s1;
	logic en_s1, clr_s1;
	logic signed [63:0] hi_q, lo_q;
	logic signed [63:0] h, tot;
	localparam logic signed [63:0] HI = (64'sd1 <<< (EB - 1)) - 64'sd1;
	localparam logic signed [63:0] LO = -HI - 64'sd1;

	// Product register, then split accumulate of the floor and the fraction.
	// The first term of a sum restarts the accumulator with its own value.
	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		en_s1   <= en;
		clr_s1  <= clr;
		if (clr_s1) begin
			hi_q <= h;
			lo_q <= prod_s1 - (h <<< 16);
		end else if (en_s1) begin
			hi_q <= hi_q + h;
			lo_q <= lo_q + (prod_s1 - (h <<< 16));
		end
	end

	always_comb begin
		h   = prod_s1 >>> 16;
		tot = hi_q + ((lo_q + 64'sd32768) >>> 16);
		if (tot > HI) res = HI[31:0];
		else if (tot < LO) res = LO[31:0];
		else res = tot[31:0];
	end
endmodule
`default_nettype wire

### src/transform_matrix_stack_engine.sv
// An error or unknown command goes to S_DONE; push and pop copy the matrix
// word by word; transform and a plain composition run on the shared MAC (64
// products for a composition); rotate adds the angle reduction and the CORDIC,
// perspective also the divider and the near-plane term. One command at a time; busy
// drops in the strobe cycle, so the next command is taken at the edge that ends it.
// The receiver cannot stall. Reset loads the identity matrix and empties the stack.
`default_nettype none
module transform_matrix_stack_engine #(
	parameter int STACK_DEPTH = tmse_pkg::STACK_DEPTH_DEF,
	parameter int WORD_WIDTH  = tmse_pkg::WORD_WIDTH_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  tmse_pkg::cmd_in_t  cmd_in,
	output logic               busy,
	output logic               done,
	output tmse_pkg::res_out_t result
);
	import tmse_pkg::*;

	localparam int EB = (WORD_WIDTH < 32) ? WORD_WIDTH : 32;
	localparam int LW = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam logic signed [63:0] SHI = (64'sd1 <<< (EB - 1)) - 64'sd1;
	localparam logic signed [63:0] SLO = -SHI - 64'sd1;

	state_t state_q, state_d;
	cmd_in_t in_q;
	logic signed [31:0] p_q [9];
	logic signed [31:0] cur_q [16];
	logic signed [31:0] m_q [16];
	logic signed [31:0] nxt_q [16];
	logic [31:0] stk_mem [STACK_DEPTH*16];
	logic signed [31:0] rd_q;
	logic [LW-1:0] lvl_q;
	logic [6:0] cnt_q;
	logic [2:0] st_q;
	logic signed [31:0] rs_q [4];
	logic signed [31:0] s_q, c_q, q_q;
	logic signed [63:0] ang_q, dv_q, ang_c;
	logic ang_neg_q;

	logic cord_go, cord_done, div_go, div_done;
	logic signed [31:0] sn, cs;
	logic [63:0] quo;
	logic signed [63:0] num_q, den_q;
	logic [63:0] un, ud;

	logic mac_clr, mac_en;
	logic signed [31:0] mac_a, mac_b, mac_r;
	logic [1:0] mi, mk, mj;

	// Saturate a 64-bit value to the entry width.
	function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
		logic signed [31:0] r;
		begin
			if (v > SHI) r = SHI[31:0];
			else if (v < SLO) r = SLO[31:0];
			else r = v[31:0];
			return r;
		end
	endfunction

	// The reduced angle gets its sign back on the way into the CORDIC.
	assign ang_c = ang_neg_q ? -ang_q : ang_q;

	tmse_cordic #(.EB(EB)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cord_go), .ang(ang_c),
		.done(cord_done), .sin_q16(sn), .cos_q16(cs)
	);

	assign un = num_q[63] ? 64'(-num_q) : 64'(num_q);
	assign ud = den_q[63] ? 64'(-den_q) : 64'(den_q);

	tmse_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go),
		.num(un + (ud >> 1)), .den(ud), .done(div_done), .quo(quo)
	);

	tmse_mac #(.EB(EB)) u_mac (
		.clk(clk), .clr(mac_clr), .en(mac_en), .a(mac_a), .b(mac_b), .res(mac_r)
	);

	// The MAC sequence: cnt = 6 bits {i,k,j}; for transform only i=0 runs.
	assign mi = cnt_q[5:4];
	assign mk = cnt_q[3:2];
	assign mj = cnt_q[1:0];
	always_comb begin
		mac_en  = (state_q == S_MAC) && !cnt_q[6];
		mac_clr = (state_q == S_MAC) && (mj == 2'd0) && !cnt_q[6];
		mac_b   = cur_q[{mj, mk}];
		if (in_q.cmd == CMD_XFORM) mac_a = p_q[mj];
		else mac_a = m_q[{mi, mj}];
	end

	// Next state and handshake.
	always_comb begin
		state_d = state_q;
		cord_go = 1'b0;
		div_go  = 1'b0;
		unique case (state_q)
			S_IDLE: if (start) state_d = S_REDUCE;
			S_REDUCE: begin
				priority case (in_q.cmd)
					CMD_ROTATE: state_d = (in_q.axis == 2'd3) ? S_DONE : S_MOD;
					CMD_PERSP: begin
						if (p_q[2] == 0 || p_q[2] == p_q[1]) state_d = S_DONE;
						else state_d = S_MOD;
					end
					CMD_TRANSLATE, CMD_SCALE, CMD_ORIENT, CMD_SHADOW, CMD_XFORM:
						state_d = S_MAC;
					CMD_PUSH: state_d = (lvl_q >= LW'(STACK_DEPTH)) ? S_DONE : S_PUSH;
					CMD_POP, CMD_POPPUSH: state_d = (lvl_q == '0) ? S_DONE : S_POP;
					default: state_d = S_DONE;
				endcase
			end
			S_MOD: if (cnt_q == 7'd14) begin
				state_d = S_CORDIC;
				cord_go = 1'b1;
			end
			S_CORDIC: if (cord_done)
				state_d = (in_q.cmd == CMD_PERSP) ? S_DIV : S_MAC;
			S_DIV: begin
				div_go = (cnt_q == 7'd0);
				if (div_done) state_d = S_NEGQ;
			end
			S_NEGQ: state_d = S_MAC;
			S_MAC: if (cnt_q == 7'd66 || (in_q.cmd == CMD_XFORM && cnt_q == 7'd18))
				state_d = (in_q.cmd == CMD_XFORM) ? S_DONE : S_WRITE;
			S_WRITE: state_d = S_DONE;
			S_PUSH: if (cnt_q == 7'd15) state_d = S_DONE;
			S_POP:  if (cnt_q == 7'd16) state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// Stack memory: one word per cycle.
	always_ff @(posedge clk) begin
		if (state_q == S_PUSH)
			stk_mem[{lvl_q[AW-1:0], cnt_q[3:0]}] <= cur_q[cnt_q[3:0]];
		rd_q <= stk_mem[{AW'(lvl_q - LW'(1)), cnt_q[3:0]}];
	end

	// Control and matrix state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= '0;
			for (int n = 0; n < 16; n++)
				cur_q[n] <= (n % 5 == 0) ? ONE_Q16 : 32'sd0;
			cnt_q <= '0;
			st_q  <= ST_OK;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					st_q  <= ST_OK;
				end
				S_REDUCE: begin
					cnt_q <= '0;
					if (in_q.cmd == CMD_ROTATE && in_q.axis == 2'd3) st_q <= ST_BAD_AXIS;
					if (in_q.cmd == CMD_PERSP && (p_q[2] == 0 || p_q[2] == p_q[1]))
						st_q <= ST_DIV_ZERO;
					if (in_q.cmd == CMD_PUSH && lvl_q >= LW'(STACK_DEPTH))
						st_q <= ST_PUSH_FULL;
					if ((in_q.cmd == CMD_POP || in_q.cmd == CMD_POPPUSH) && lvl_q == '0)
						st_q <= ST_POP_EMPTY;
				end
				S_MOD: cnt_q <= cnt_q + 7'd1;
				S_CORDIC: cnt_q <= '0;
				S_DIV: cnt_q <= 7'd1;
				S_NEGQ: cnt_q <= '0;
				S_MAC: cnt_q <= cnt_q + 7'd1;
				S_WRITE: for (int n = 0; n < 16; n++) cur_q[n] <= nxt_q[n];
				S_PUSH: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd15) lvl_q <= lvl_q + LW'(1);
				end
				S_POP: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q != 7'd0) cur_q[4'(cnt_q - 7'd1)] <= rd_q;
					if (cnt_q == 7'd16 && in_q.cmd == CMD_POP) lvl_q <= lvl_q - LW'(1);
				end
				S_DONE: done <= 1'b1;
				default: ;
			endcase
		end
	end

	// Operand capture, built matrix and MAC results.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			in_q  <= cmd_in;
			p_q[0] <= sat64(64'(cmd_in.p0)); p_q[1] <= sat64(64'(cmd_in.p1));
			p_q[2] <= sat64(64'(cmd_in.p2)); p_q[3] <= sat64(64'(cmd_in.p3));
			p_q[4] <= sat64(64'(cmd_in.p4)); p_q[5] <= sat64(64'(cmd_in.p5));
			p_q[6] <= sat64(64'(cmd_in.p6)); p_q[7] <= sat64(64'(cmd_in.p7));
			p_q[8] <= sat64(64'(cmd_in.p8));
			for (int n = 0; n < 4; n++) rs_q[n] <= '0;
		end
		if (state_q == S_REDUCE) begin
			for (int n = 0; n < 16; n++)
				m_q[n] <= (n % 5 == 0) ? ONE_Q16 : 32'sd0;
			// Angle magnitude in Q.30; the remainder keeps the sign of the angle.
			ang_neg_q <= p_q[0][31];
			dv_q      <= TWO_PI_Q30 <<< 13;
			if (in_q.cmd == CMD_ROTATE)
				ang_q <= (p_q[0][31] ? -64'(p_q[0]) : 64'(p_q[0])) <<< 14;
			else
				ang_q <= (p_q[0][31] ? -64'(p_q[0]) : 64'(p_q[0])) <<< 13;
			unique case (in_q.cmd)
				CMD_TRANSLATE: begin
					m_q[12] <= p_q[0]; m_q[13] <= p_q[1]; m_q[14] <= p_q[2];
				end
				CMD_SCALE: begin
					m_q[0] <= p_q[0]; m_q[5] <= p_q[1]; m_q[10] <= p_q[2];
				end
				CMD_ORIENT: begin
					m_q[0] <= p_q[0]; m_q[4] <= p_q[1]; m_q[8] <= p_q[2];
					m_q[1] <= p_q[3]; m_q[5] <= p_q[4]; m_q[9] <= p_q[5];
					m_q[2] <= p_q[6]; m_q[6] <= p_q[7]; m_q[10] <= p_q[8];
				end
				CMD_SHADOW: begin
					m_q[0] <= p_q[2]; m_q[5] <= p_q[2];
					m_q[8] <= sat64(-64'(p_q[0])); m_q[9] <= sat64(-64'(p_q[1]));
					m_q[10] <= '0;
					m_q[11] <= in_q.local_light ? -ONE_Q16 : 32'sd0;
					m_q[15] <= p_q[2];
				end
				default: ;
			endcase
		end
		// Modulo two pi by compare and subtract of 2*pi shifted down one bit a cycle.
		if (state_q == S_MOD && cnt_q < 7'd14) begin
			if (ang_q >= dv_q) ang_q <= ang_q - dv_q;
			dv_q <= dv_q >>> 1;
		end
		if (state_q == S_CORDIC && cord_done) begin
			s_q <= sn;
			c_q <= cs;
			num_q <= 64'(sn) * 64'(p_q[2]);
			den_q <= 64'(p_q[2]) - 64'(p_q[1]);
			if (in_q.cmd == CMD_ROTATE) begin
				priority case (in_q.axis)
					2'd0: begin m_q[5] <= cs; m_q[10] <= cs; m_q[6] <= -sn; m_q[9] <= sn; end
					2'd1: begin m_q[0] <= cs; m_q[10] <= cs; m_q[2] <= sn; m_q[8] <= -sn; end
					default: begin m_q[0] <= cs; m_q[5] <= cs; m_q[1] <= -sn; m_q[4] <= sn; end
				endcase
			end
		end
		if (state_q == S_DIV && div_done)
			q_q <= sat64((num_q[63] != den_q[63]) ? -$signed(quo) : $signed(quo));
		if (state_q == S_NEGQ) begin
			m_q[0] <= c_q; m_q[5] <= c_q; m_q[10] <= q_q; m_q[11] <= s_q;
			m_q[15] <= '0;
			m_q[14] <= sat64(-64'(sat64((64'(q_q) * 64'(p_q[1]) + 64'sd32768) >>> 16)));
		end
		// A dot product is captured once its last term has passed the product register and the accumulator.
		if (state_q == S_MAC && cnt_q >= 7'd5 && cnt_q[1:0] == 2'd1) begin
			if (in_q.cmd == CMD_XFORM) rs_q[2'(cnt_q[5:2] - 4'd1)] <= mac_r;
			else nxt_q[4'(cnt_q[5:2] - 4'd1)] <= mac_r;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign result.out_x  = rs_q[0];
	assign result.out_y  = rs_q[1];
	assign result.out_z  = rs_q[2];
	assign result.out_w  = rs_q[3];
	assign result.status = st_q;

	// Every result strobe follows a busy engine.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without command");
	// The stack level never exceeds its depth.
	a_lvl: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_q <= LW'(STACK_DEPTH)) else $error("stack overflow");
	// A failed push leaves the level unchanged.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && st_q == ST_PUSH_FULL) |-> $stable(lvl_q)) else $error("bad push");
endmodule
`default_nettype wire

### test/tmse_checker.sv
`default_nettype none
module tmse_checker (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  wire                busy,
	input  tmse_pkg::cmd_in_t  cmd_in,
	input  wire                done,
	input  tmse_pkg::res_out_t result,
	output int                 errors,
	output int                 pending
);
	import tmse_pkg::*;

	localparam int DEPTH = STACK_DEPTH_DEF;
	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;

	// Shadow copy of the engine state.
	longint   cur_m [16];
	longint   saved [DEPTH][16];
	int       level;
	res_out_t expected_q [$];

	assign pending = expected_q.size();

	function automatic longint sat_q(input longint v);
		if (v > Q_MAX) return Q_MAX;
		if (v < Q_MIN) return Q_MIN;
		return v;
	endfunction

	function automatic longint qmul(input longint a, input longint b);
		return sat_q((a * b + 32768) >>> 16);
	endfunction

	// Exact sum of four products, rounded once; split so the sum cannot overflow.
	function automatic longint round_sum4(input longint a [4], input longint b [4]);
		longint hi, lo, p, h;
		hi = 0;
		lo = 0;
		for (int i = 0; i < 4; i++) begin
			p = a[i] * b[i];
			h = p >>> 16;
			hi += h;
			lo += p - h * 65536;
		end
		return sat_q(hi + ((lo + 32768) >>> 16));
	endfunction

	// Angle in Q.30 radians to sine and cosine in Q16.16 by rotation-mode CORDIC.
	function automatic void sin_cos(input longint ang, output longint s, output longint c);
		longint x, y, z, r, t, dx, dy;
		bit     flip;
		x = K_Q30;
		y = 0;
		flip = 0;
		r = ang % TWO_PI_Q30;
		if (r > PI_Q30) r -= TWO_PI_Q30;
		if (r < -PI_Q30) r += TWO_PI_Q30;
		if (r > HALF_PI_Q30) begin
			r = PI_Q30 - r;
			flip = 1;
		end else if (r < -HALF_PI_Q30) begin
			r = -PI_Q30 - r;
			flip = 1;
		end
		z = r;
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			t = atan_q30(5'(i));
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= t;
			end else begin
				x += dx;
				y -= dy;
				z += t;
			end
		end
		s = sat_q((y + 8192) >>> 14);
		c = sat_q((x + 8192) >>> 14);
		if (flip) c = -c;
	endfunction

	// Replace the current matrix with m * current.
	function automatic void premultiply(input longint m [16]);
		longint n [16];
		longint a [4];
		longint b [4];
		for (int i = 0; i < 4; i++)
			for (int k = 0; k < 4; k++) begin
				for (int j = 0; j < 4; j++) begin
					a[j] = m[i * 4 + j];
					b[j] = cur_m[j * 4 + k];
				end
				n[i * 4 + k] = round_sum4(a, b);
			end
		cur_m = n;
	endfunction

	function automatic void load_identity(output longint m [16]);
		for (int i = 0; i < 16; i++)
			m[i] = (i % 5 == 0) ? 64'sd65536 : 64'sd0;
	endfunction

	// Apply one command to the shadow state and return the answer it gives.
	function automatic res_out_t apply_command(input cmd_in_t c);
		res_out_t r;
		longint   p [9];
		longint   m [16];
		longint   a [4];
		longint   b [4];
		longint   s, co, num, den, q;
		longint unsigned un, ud;
		r = '0;
		r.status = ST_OK;
		p = '{c.p0, c.p1, c.p2, c.p3, c.p4, c.p5, c.p6, c.p7, c.p8};
		load_identity(m);
		case (c.cmd)
			CMD_TRANSLATE: begin
				m[12] = p[0]; m[13] = p[1]; m[14] = p[2];
				premultiply(m);
			end
			CMD_SCALE: begin
				m[0] = p[0]; m[5] = p[1]; m[10] = p[2];
				premultiply(m);
			end
			CMD_ROTATE: begin
				if (c.axis == 2'd3) begin
					r.status = ST_BAD_AXIS;
				end else begin
					sin_cos(p[0] * 16384, s, co);
					if (c.axis == 2'd0) begin
						m[5] = co; m[10] = co; m[6] = -s; m[9] = s;
					end else if (c.axis == 2'd1) begin
						m[0] = co; m[10] = co; m[2] = s; m[8] = -s;
					end else begin
						m[0] = co; m[5] = co; m[1] = -s; m[4] = s;
					end
					premultiply(m);
				end
			end
			CMD_PERSP: begin
				if (p[2] == 0 || p[2] == p[1]) begin
					r.status = ST_DIV_ZERO;
				end else begin
					sin_cos(p[0] * 8192, s, co);
					num = s * p[2];
					den = p[2] - p[1];
					un = (num < 0) ? longint'(-num) : longint'(num);
					ud = (den < 0) ? longint'(-den) : longint'(den);
					q = longint'((un + ud / 2) / ud);
					if ((num < 0) != (den < 0)) q = -q;
					q = sat_q(q);
					m[0] = co; m[5] = co;
					m[10] = q;
					m[14] = sat_q(-qmul(q, p[1]));
					m[11] = s;
					m[15] = 0;
					premultiply(m);
				end
			end
			CMD_ORIENT: begin
				m[0] = p[0]; m[4] = p[1]; m[8] = p[2];
				m[1] = p[3]; m[5] = p[4]; m[9] = p[5];
				m[2] = p[6]; m[6] = p[7]; m[10] = p[8];
				premultiply(m);
			end
			CMD_SHADOW: begin
				m[0] = p[2]; m[5] = p[2];
				m[8] = sat_q(-p[0]); m[9] = sat_q(-p[1]);
				m[10] = 0;
				m[11] = c.local_light ? -64'sd65536 : 64'sd0;
				m[15] = p[2];
				premultiply(m);
			end
			CMD_PUSH: begin
				if (level >= DEPTH) begin
					r.status = ST_PUSH_FULL;
				end else begin
					saved[level] = cur_m;
					level++;
				end
			end
			CMD_POP, CMD_POPPUSH: begin
				if (level == 0) begin
					r.status = ST_POP_EMPTY;
				end else begin
					cur_m = saved[level - 1];
					if (c.cmd == CMD_POP) level--;
				end
			end
			CMD_XFORM: begin
				for (int j = 0; j < 4; j++) a[j] = p[j];
				for (int i = 0; i < 4; i++) begin
					for (int j = 0; j < 4; j++) b[j] = cur_m[j * 4 + i];
					case (i)
						0: r.out_x = 32'(round_sum4(a, b));
						1: r.out_y = 32'(round_sum4(a, b));
						2: r.out_z = 32'(round_sum4(a, b));
						default: r.out_w = 32'(round_sum4(a, b));
					endcase
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Compare finished transactions first, then record the one accepted at this edge.
	always @(posedge clk or negedge arst_n) begin
		res_out_t e;
		if (!arst_n) begin
			load_identity(cur_m);
			level = 0;
			errors = 0;
			expected_q.delete();
		end else begin
			if (done) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, result);
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (result.out_x !== e.out_x || result.out_y !== e.out_y ||
					    result.out_z !== e.out_z || result.out_w !== e.out_w ||
					    result.status !== e.status) begin
						$display("%0t: mismatch expected x=%h y=%h z=%h w=%h st=%0d",
							$time, e.out_x, e.out_y, e.out_z, e.out_w, e.status);
						$display("%0t:          actual   x=%h y=%h z=%h w=%h st=%0d",
							$time, result.out_x, result.out_y, result.out_z,
							result.out_w, result.status);
						errors++;
					end
				end
			end
			if (start && !busy)
				expected_q.push_back(apply_command(cmd_in));
		end
	end
endmodule
`default_nettype wire

### test/tb_top.sv
`default_nettype none
module tb_top;
	import tmse_pkg::*;

	localparam int Q1 = 65536;
	localparam int RANDOM_ITEMS = 890;
	localparam int CYCLE_LIMIT = 1000000;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	cmd_in_t  cmd_in = '0;
	logic     busy, done;
	res_out_t result;
	int       errors, pending;
	int       cycles = 0;
	bit       no_gaps = 0;

	transform_matrix_stack_engine u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd_in(cmd_in),
		.busy(busy), .done(done), .result(result)
	);

	tmse_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd_in(cmd_in),
		.done(done), .result(result), .errors(errors), .pending(pending)
	);

	always #5 clk = ~clk;

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// Signed Q16.16 value uniformly in [-lim, lim].
	function automatic int near_zero(input int lim);
		return int'($urandom_range(0, 2 * lim)) - lim;
	endfunction

	function automatic cmd_in_t make_cmd(input cmd_t op);
		cmd_in_t     c;
		logic [319:0] bits_r;
		bits_r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom};
		c = bits_r[$bits(cmd_in_t)-1:0];
		c.cmd = op;
		return c;
	endfunction

	// Random command, mostly with operands that keep the matrix in a useful range.
	function automatic cmd_in_t random_cmd();
		cmd_in_t c;
		int      r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			c = make_cmd(CMD_TRANSLATE);
			c.p0 = near_zero(8 * Q1); c.p1 = near_zero(8 * Q1); c.p2 = near_zero(8 * Q1);
		end else if (r < 18) begin
			c = make_cmd(CMD_SCALE);
			c.p0 = near_zero(3 * Q1 / 2); c.p1 = near_zero(3 * Q1 / 2);
			c.p2 = near_zero(3 * Q1 / 2);
		end else if (r < 30) begin
			c = make_cmd(CMD_ROTATE);
			if ($urandom_range(0, 4) != 0) c.p0 = near_zero(7 * Q1);
		end else if (r < 36) begin
			c = make_cmd(CMD_PERSP);
			c.p0 = near_zero(3 * Q1);
			c.p1 = near_zero(4 * Q1);
			c.p2 = near_zero(64 * Q1);
			if ($urandom_range(0, 9) == 0) c.p2 = 0;
			else if ($urandom_range(0, 9) == 0) c.p2 = c.p1;
		end else if (r < 42) begin
			c = make_cmd(CMD_ORIENT);
			c.p0 = near_zero(Q1); c.p1 = near_zero(Q1); c.p2 = near_zero(Q1);
			c.p3 = near_zero(Q1); c.p4 = near_zero(Q1); c.p5 = near_zero(Q1);
			c.p6 = near_zero(Q1); c.p7 = near_zero(Q1); c.p8 = near_zero(Q1);
		end else if (r < 46) begin
			c = make_cmd(CMD_SHADOW);
			c.p0 = near_zero(4 * Q1); c.p1 = near_zero(4 * Q1); c.p2 = near_zero(4 * Q1);
		end else if (r < 58) begin
			c = make_cmd(CMD_PUSH);
		end else if (r < 70) begin
			c = make_cmd(CMD_POP);
		end else if (r < 76) begin
			c = make_cmd(CMD_POPPUSH);
		end else if (r < 96) begin
			c = make_cmd(CMD_XFORM);
			if ($urandom_range(0, 9) < 7) begin
				c.p0 = near_zero(16 * Q1); c.p1 = near_zero(16 * Q1);
				c.p2 = near_zero(16 * Q1); c.p3 = near_zero(2 * Q1);
			end
		end else begin
			c = make_cmd(CMD_XFORM);
			c.cmd = 4'($urandom_range(10, 15));
		end
		return c;
	endfunction

	// Drive one transaction at the falling edge and hold it until accepted.
	task automatic send(input cmd_in_t c);
		if (!no_gaps && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		start <= 1'b1;
		cmd_in <= c;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic send_op(input cmd_t op, input int a, input int b, input int d);
		cmd_in_t c;
		c = make_cmd(op);
		c.p0 = a; c.p1 = b; c.p2 = d;
		send(c);
	endtask

	initial begin
		cmd_in_t c;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty stack errors, each operation, and the error cases.
		send_op(CMD_POP, 0, 0, 0);
		send_op(CMD_POPPUSH, 0, 0, 0);
		c = make_cmd(CMD_XFORM);
		c.p0 = 32'sh7fffffff; c.p1 = 32'sh80000000; c.p2 = -1; c.p3 = Q1;
		send(c);
		send_op(CMD_TRANSLATE, 2 * Q1, -Q1, Q1 / 2);
		send_op(CMD_PUSH, 0, 0, 0);
		send_op(CMD_SCALE, 2 * Q1, 2 * Q1, -Q1);
		for (int ax = 0; ax < 4; ax++) begin
			c = make_cmd(CMD_ROTATE);
			c.p0 = Q1 + ax * 40000;
			c.axis = 2'(ax);
			send(c);
		end
		c = make_cmd(CMD_ROTATE);
		c.p0 = 32'sh80000000;
		c.axis = 2'd2;
		send(c);
		send_op(CMD_PERSP, Q1, Q1, 100 * Q1);
		send_op(CMD_PERSP, Q1, Q1, 0);
		send_op(CMD_PERSP, Q1, 5 * Q1, 5 * Q1);
		c = make_cmd(CMD_ORIENT);
		c.p0 = Q1; c.p1 = 0; c.p2 = 0; c.p3 = 0; c.p4 = 0; c.p5 = Q1;
		c.p6 = 0; c.p7 = -Q1; c.p8 = 0;
		send(c);
		c = make_cmd(CMD_SHADOW);
		c.p0 = Q1; c.p1 = 2 * Q1; c.p2 = 3 * Q1; c.local_light = 1'b1;
		send(c);
		c.local_light = 1'b0;
		send(c);
		send_op(CMD_XFORM, Q1, Q1, Q1);
		send_op(CMD_POPPUSH, 0, 0, 0);
		send_op(CMD_POP, 0, 0, 0);
		send_op(CMD_SCALE, 32'sh7fffffff, 32'sh80000000, Q1);
		send_op(CMD_XFORM, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
		c = make_cmd(CMD_XFORM);
		c.cmd = 4'hf;
		send(c);
		send_op(CMD_POP, 0, 0, 0);

		// Random part, with one deep push and pop run to reach the full stack.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3) begin
				start <= 1'b0;
				while (pending != 0) @(negedge clk);
				for (int k = 0; k < 18; k++) send_op(CMD_PUSH, 0, 0, 0);
				send(random_cmd());
				for (int k = 0; k < 18; k++) send_op(CMD_POP, 0, 0, 0);
			end
			if (n == RANDOM_ITEMS * 4 / 5) no_gaps = 1;
			send(random_cmd());
		end
		start <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (errors == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

### filelist.f
src/tmse_pkg.sv
src/tmse_cordic.sv
src/tmse_divider.sv
src/tmse_mac.sv
src/transform_matrix_stack_engine.sv
test/tmse_checker.sv
test/tb_top.sv
